// ===== design/nearest_palette_color_search_top_assert.svh =====
// Assertion macros used by the nearest palette color search checker.
`ifndef NEAREST_PALETTE_COLOR_SEARCH_TOP_ASSERT_SVH
`define NEAREST_PALETTE_COLOR_SEARCH_TOP_ASSERT_SVH

// Same-cycle implication, disabled while reset is active.
`define NPCS_ASSERT_NOW(lbl, ck, rst_n, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("npcs check failed");

// Next-cycle implication, disabled while reset is active.
`define NPCS_ASSERT_NEXT(lbl, ck, rst_n, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("npcs check failed");

`endif

// ===== design/npcs_pkg.sv =====
// Types and constants of the nearest palette color search.
package npcs_pkg;

	localparam int unsigned CHAN_W    = 8;
	localparam int unsigned IDX_W     = 8;
	localparam int unsigned DIST_W    = 18;
	localparam int unsigned SQ_W      = 2 * CHAN_W;
	localparam int unsigned COUNT_W   = 9;
	localparam int unsigned MAX_CELLS = 256;

	localparam logic MODE_LOAD  = 1'b0;
	localparam logic MODE_QUERY = 1'b1;

	localparam logic [COUNT_W-1:0] ENTRIES_RESET = 9'd256;

	typedef struct packed {
		logic              mode;
		logic [IDX_W-1:0]  entry_index;
		logic [CHAN_W-1:0] red_level;
		logic [CHAN_W-1:0] green_level;
		logic [CHAN_W-1:0] blue_level;
	} npcs_in_t;

	typedef struct packed {
		logic [IDX_W-1:0]  nearest_index;
		logic [DIST_W-1:0] nearest_distance;
	} npcs_out_t;

	typedef struct packed {
		logic [CHAN_W-1:0] red;
		logic [CHAN_W-1:0] green;
		logic [CHAN_W-1:0] blue;
	} npcs_color_t;

	// Entry write broadcast to every cell.
	typedef struct packed {
		logic             en;
		logic [IDX_W-1:0] idx;
		npcs_color_t      color;
	} npcs_wr_t;

	// Running best handed from cell to cell.
	typedef struct packed {
		logic              valid;
		logic [IDX_W-1:0]  idx;
		logic [DIST_W-1:0] sq_dist;
	} npcs_best_t;

endpackage

// ===== design/npcs_cell.sv =====
// One palette cell: holds an entry, its distance to the query and a stage of the running best.
module npcs_cell
	import npcs_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic [IDX_W-1:0] cell_idx,
	input  logic             active,
	input  npcs_wr_t         wr,
	input  npcs_color_t      query,
	input  npcs_best_t       best_in,
	output npcs_best_t       best_out
);

	npcs_color_t       entry_q;
	logic [DIST_W-1:0] dist_q;
	npcs_best_t        best_q;

	logic [CHAN_W-1:0] dr, dg, db;
	logic [SQ_W-1:0]   sr, sg, sb;
	logic [DIST_W-1:0] dist_d;
	logic              take;

	always_comb begin
		dr     = (entry_q.red   > query.red)   ? entry_q.red   - query.red
		                                       : query.red   - entry_q.red;
		dg     = (entry_q.green > query.green) ? entry_q.green - query.green
		                                       : query.green - entry_q.green;
		db     = (entry_q.blue  > query.blue)  ? entry_q.blue  - query.blue
		                                       : query.blue  - entry_q.blue;
		sr     = SQ_W'(dr) * SQ_W'(dr);
		sg     = SQ_W'(dg) * SQ_W'(dg);
		sb     = SQ_W'(db) * SQ_W'(db);
		dist_d = DIST_W'(sr) + DIST_W'(sg) + DIST_W'(sb);
	end

	// strict less-than keeps the lower index on a tie
	assign take = active && (!best_in.valid || (dist_q < best_in.sq_dist));

	always_ff @(posedge clk) begin
		if (wr.en && (wr.idx == cell_idx)) begin
			entry_q <= wr.color;
		end
		dist_q <= dist_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			best_q <= '0;
		end else if (take) begin
			best_q <= '{valid: 1'b1, idx: cell_idx, sq_dist: dist_q};
		end else begin
			best_q <= best_in;
		end
	end

	assign best_out = best_q;

endmodule

// ===== design/nearest_palette_color_search_top.sv =====
// Top level of the nearest palette color search: cell row, scan sequencer and result register.
//
//  channel  | direction | valid         | stall         | beat payload
//  ---------+-----------+---------------+---------------+-----------------------------
//  item     | in        | item_valid    | item_stall    | item   (npcs_in_t)
//  result   | out       | result_valid  | result_stall  | result (npcs_out_t)
//  config   | in        | wr_en         | (none)        | wr_data (entries_in_use)
//
// A load beat never raises item_stall. A query beat holds item_stall high until its scan
// finishes, and the next beat is taken after that; its result passes through these registers:
// the squared distance in each cell, the best walking the row of NCELL cells, one result register.
// Reset clears control and the running best only; entries hold garbage until written.
// A stalled result holds the scan at its end and keeps item_stall high; one finished result
// may wait while the next beat is taken.
module nearest_palette_color_search_top
	import npcs_pkg::*;
#(
	parameter int unsigned PALETTE_DEPTH = 256
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               item_valid,
	output logic               item_stall,
	input  npcs_in_t           item,
	output logic               result_valid,
	input  logic               result_stall,
	output npcs_out_t          result,
	input  logic               wr_en,
	input  logic [COUNT_W-1:0] wr_data
);

	// load beats address at most MAX_CELLS entries
	localparam int unsigned NCELL = (PALETTE_DEPTH > MAX_CELLS) ? MAX_CELLS : PALETTE_DEPTH;
	localparam int unsigned CNT_W = $clog2(NCELL + 2);
	localparam logic [CNT_W-1:0] DONE_CNT = CNT_W'(NCELL + 1);

	logic [COUNT_W-1:0] entries_q;
	logic               busy_q;
	logic [CNT_W-1:0]   cnt_q;
	npcs_color_t        query_q;
	logic               out_valid_q;
	npcs_out_t          out_q;

	logic       accept;
	logic       finish;
	npcs_wr_t   wr;
	npcs_best_t chain [NCELL+1];

	assign accept = item_valid && !item_stall;
	// the last cell output is settled once the counter reaches DONE_CNT
	assign finish = busy_q && (cnt_q == DONE_CNT) && (!out_valid_q || !result_stall);

	assign item_stall = busy_q;

	// Broadcast a load to every cell; only the matching cell keeps it.
	always_comb begin
		wr.en          = accept && (item.mode == MODE_LOAD);
		wr.idx         = item.entry_index;
		wr.color.red   = item.red_level;
		wr.color.green = item.green_level;
		wr.color.blue  = item.blue_level;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entries_q <= ENTRIES_RESET;
		end else if (wr_en) begin
			entries_q <= wr_data;
		end
	end

	// Scan sequencer: start on a query beat, advance once per cycle, hold at the end.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (accept && (item.mode == MODE_QUERY)) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (finish) begin
			busy_q <= 1'b0;
		end else if (busy_q && (cnt_q != DONE_CNT)) begin
			cnt_q <= cnt_q + CNT_W'(1);
		end
	end

	// Hold the query color for the whole scan.
	always_ff @(posedge clk) begin
		if (accept && (item.mode == MODE_QUERY)) begin
			query_q.red   <= item.red_level;
			query_q.green <= item.green_level;
			query_q.blue  <= item.blue_level;
		end
	end

	assign chain[0] = '0;

	for (genvar i = 0; i < NCELL; i++) begin : g_cell
		localparam logic [COUNT_W-1:0] CELL_NUM = COUNT_W'(i);
		logic active;

		// entry zero is always searched; the count saturates at the row length
		assign active = (i == 0) || (CELL_NUM < entries_q);

		npcs_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.cell_idx (IDX_W'(i)),
			.active   (active),
			.wr       (wr),
			.query    (query_q),
			.best_in  (chain[i]),
			.best_out (chain[i+1])
		);
	end

	// Result register: drop the beat when taken, load a new one at scan end.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (finish) begin
			out_valid_q <= 1'b1;
		end else if (!result_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (finish) begin
			out_q.nearest_index    <= chain[NCELL].idx;
			out_q.nearest_distance <= chain[NCELL].sq_dist;
		end
	end

	assign result_valid = out_valid_q;
	assign result       = out_q;

endmodule

// ===== design/npcs_checker.sv =====
// Port-level checker for the nearest palette color search, bound to the top level.
`include "nearest_palette_color_search_top_assert.svh"

module npcs_checker
	import npcs_pkg::*;
(
	input logic      clk,
	input logic      arst_n,
	input logic      item_valid,
	input logic      item_stall,
	input npcs_in_t  item,
	input logic      result_valid,
	input logic      result_stall,
	input npcs_out_t result
);

	localparam logic [DIST_W-1:0] MAX_DIST = 18'd195075;

	logic query_beat;

	assign query_beat = item_valid && !item_stall && (item.mode == MODE_QUERY);

	// a query beat occupies the block on the next cycle
	`NPCS_ASSERT_NEXT(a_query_busy, clk, arst_n, query_beat, item_stall)

	// a new result only shows up at the end of a scan
	`NPCS_ASSERT_NOW(a_result_after_scan, clk, arst_n, $rose(result_valid), $past(item_stall))

	`NPCS_ASSERT_NOW(a_dist_range, clk, arst_n, result_valid,
		result.nearest_distance <= MAX_DIST)

	`NPCS_ASSERT_NEXT(a_result_hold, clk, arst_n, result_valid && result_stall,
		result_valid && $stable(result))

endmodule

bind nearest_palette_color_search_top npcs_checker u_npcs_checker (.*);

// ===== tb/tb.sv =====
// Self-checking testbench for the nearest palette color search top level.
module tb;
	import npcs_pkg::*;

	// Run shape: a directed table, a full palette fill, then random phases.
	localparam int ITEMS_PER_PHASE = 180;
	localparam int PHASES          = 9;
	localparam int DIR_ROWS        = 20;
	// One full scan of the cell row plus margin; used before count writes and at the end.
	localparam int DRAIN_CYCLES    = MAX_CELLS + 8;
	localparam int HOLDOFF_CYCLES  = 3000;
	// Cycles with no beat on either channel before the run is declared hung.
	localparam int QUIET_LIMIT     = 20000;
	// Phase in which the sender waits for every result, and the one with the long hold-off.
	localparam int PAUSE_PHASE     = 2;
	localparam int HOLD_PHASE      = 4;
	// Markers in the count column of the tables.
	localparam int KEEP_COUNT      = -1;
	localparam int PICK_RANDOM     = -2;

	typedef struct {
		int        count_cfg;
		npcs_in_t  beat;
		bit        has_exp;
		npcs_out_t exp_res;
	} dir_row_t;

	typedef struct {
		int count_cfg;
		int send_idle_pct;
		int recv_stall_pct;
	} phase_t;

	logic               clk;
	logic               arst_n;
	logic               item_valid;
	logic               item_stall;
	npcs_in_t           item;
	logic               result_valid;
	logic               result_stall;
	npcs_out_t          result;
	logic               wr_en;
	logic [COUNT_W-1:0] wr_data;

	// Mirror of the block: palette contents and the programmed entry count.
	npcs_color_t palette_mirror [MAX_CELLS];
	int          scan_cfg;
	// Nearest-entry answers still owed by the block, oldest first.
	npcs_out_t   pending_nearest [$];

	int       send_idle_pct;
	int       recv_stall_pct;
	bit       holdoff_req;
	int       hold_left;
	int       miss_count;
	int       quiet_cycles;
	dir_row_t directed_rows [DIR_ROWS];
	phase_t   phases [PHASES];

	nearest_palette_color_search_top dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result),
		.wr_en        (wr_en),
		.wr_data      (wr_data)
	);

	initial begin
		clk = 1'b0;
		forever begin
			#5 clk = ~clk;
		end
	end

	// Number of entries a query walks: a count of zero still searches entry zero,
	// and anything past the palette size saturates.
	function automatic int scan_len();
		if (scan_cfg < 1)
			return 1;
		if (scan_cfg > MAX_CELLS)
			return MAX_CELLS;
		return scan_cfg;
	endfunction

	function automatic int unsigned sq_gap(logic [CHAN_W-1:0] a, logic [CHAN_W-1:0] b);
		int d;
		d = int'(a) - int'(b);
		return d * d;
	endfunction

	// Walk the mirrored palette from index zero; only a strictly smaller distance
	// replaces the best, so the lowest index wins a tie.
	function automatic npcs_out_t find_nearest(npcs_color_t q);
		npcs_out_t   best;
		int unsigned best_dist;
		int unsigned d;
		best      = '0;
		best_dist = '1;
		for (int i = 0; i < scan_len(); i++) begin
			d = sq_gap(palette_mirror[i].red, q.red) + sq_gap(palette_mirror[i].green, q.green)
				+ sq_gap(palette_mirror[i].blue, q.blue);
			if (d < best_dist) begin
				best_dist             = d;
				best.nearest_index    = IDX_W'(i);
				best.nearest_distance = DIST_W'(d);
			end
		end
		return best;
	endfunction

	function automatic dir_row_t row(int cfg, logic mode, int idx, int r, int g, int b,
			bit has_exp, int exp_idx, int exp_dist);
		dir_row_t x;
		x.count_cfg                = cfg;
		x.beat.mode                = mode;
		x.beat.entry_index         = IDX_W'(idx);
		x.beat.red_level           = CHAN_W'(r);
		x.beat.green_level         = CHAN_W'(g);
		x.beat.blue_level          = CHAN_W'(b);
		x.has_exp                  = has_exp;
		x.exp_res.nearest_index    = IDX_W'(exp_idx);
		x.exp_res.nearest_distance = DIST_W'(exp_dist);
		return x;
	endfunction

	// Colors: some copied from a searched entry (exact hits on queries, duplicate
	// entries and ties on loads), some on the cube corners, the rest uniform.
	function automatic npcs_color_t pick_color();
		npcs_color_t c;
		case ($urandom_range(9))
			0, 1: begin
				c = palette_mirror[$urandom_range(scan_len() - 1)];
			end
			2: begin
				c.red   = $urandom_range(1) ? 8'hFF : 8'h00;
				c.green = $urandom_range(1) ? 8'hFF : 8'h00;
				c.blue  = $urandom_range(1) ? 8'hFF : 8'h00;
			end
			default: begin
				c = npcs_color_t'(24'($urandom));
			end
		endcase
		return c;
	endfunction

	function automatic npcs_in_t pick_beat();
		npcs_in_t x;
		x.mode        = $urandom_range(1) ? MODE_QUERY : MODE_LOAD;
		x.entry_index = IDX_W'($urandom);
		{x.red_level, x.green_level, x.blue_level} = pick_color();
		return x;
	endfunction

	// Count a failure; print only the first ten.
	task automatic flag_miss(string msg);
		if (miss_count < 10)
			$display("%0t: %s", $realtime, msg);
		miss_count++;
	endtask

	// Offer one beat, called at a falling edge. Insert random idle cycles first,
	// then hold the payload until a rising edge sees stall low. On acceptance,
	// update the mirror for a load or queue the answer for a query.
	task automatic offer_beat(npcs_in_t x, bit has_exp, npcs_out_t exp_res);
		npcs_color_t c;
		while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
			item_valid <= 1'b0;
			@(negedge clk);
		end
		item       <= x;
		item_valid <= 1'b1;
		do begin
			@(posedge clk);
		end while (item_stall !== 1'b0);
		c = '{x.red_level, x.green_level, x.blue_level};
		if (x.mode == MODE_LOAD)
			palette_mirror[x.entry_index] = c;
		else
			pending_nearest.push_back(has_exp ? exp_res : find_nearest(c));
		@(negedge clk);
	endtask

	// Write the entry count only with the block idle: drop valid, wait for every
	// owed answer, then one scan's worth of cycles in case a load trails the last query.
	task automatic set_entry_count(int v);
		item_valid <= 1'b0;
		while (pending_nearest.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
		wr_en   <= 1'b1;
		wr_data <= COUNT_W'(v);
		@(negedge clk);
		wr_en    <= 1'b0;
		scan_cfg  = v;
	endtask

	// Result side: random stall, or a long hold-off when the stimulus asks for one.
	initial begin
		result_stall = 1'b0;
		hold_left    = 0;
		forever begin
			@(negedge clk);
			if (holdoff_req) begin
				hold_left   = HOLDOFF_CYCLES;
				holdoff_req = 1'b0;
			end
			if (hold_left > 0) begin
				hold_left--;
				result_stall <= 1'b1;
			end else begin
				result_stall <= ($urandom_range(99) < recv_stall_pct);
			end
		end
	end

	// Check every accepted result against the oldest owed answer, and watch for a hang.
	always @(posedge clk) begin
		npcs_out_t want;
		if (arst_n) begin
			if (result_valid === 1'b1 && result_stall === 1'b0) begin
				if (pending_nearest.size() == 0) begin
					flag_miss($sformatf("unexpected result: index %0d distance %0d",
						result.nearest_index, result.nearest_distance));
				end else begin
					want = pending_nearest.pop_front();
					if (result.nearest_index !== want.nearest_index
							|| result.nearest_distance !== want.nearest_distance)
						flag_miss($sformatf("expected index %0d distance %0d, got index %0d distance %0d",
							want.nearest_index, want.nearest_distance,
							result.nearest_index, result.nearest_distance));
				end
			end
			if ((item_valid && !item_stall) || (result_valid && !result_stall)) begin
				quiet_cycles = 0;
			end else begin
				quiet_cycles++;
				if (quiet_cycles >= QUIET_LIMIT) begin
					$display("Verification failed");
					$finish;
				end
			end
		end
	end

	initial begin
		npcs_in_t beat;
		int       cfg;

		arst_n         = 1'b0;
		item_valid     = 1'b0;
		item           = '0;
		wr_en          = 1'b0;
		wr_data        = '0;
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		holdoff_req    = 1'b0;
		miss_count     = 0;
		quiet_cycles   = 0;
		scan_cfg       = ENTRIES_RESET;
		foreach (palette_mirror[i])
			palette_mirror[i] = '0;

		// Directed beats. Typed answers are the ones obvious by eye: black against
		// white, exact hits, ties that must go to the lower index, and a count of
		// zero or one that hides a closer entry further up.
		directed_rows = '{
			row(0,          MODE_LOAD,  0,   0,   0,   0,   0, 0, 0),
			row(KEEP_COUNT, MODE_QUERY, 0,   0,   0,   0,   1, 0, 0),
			row(KEEP_COUNT, MODE_QUERY, 255, 255, 255, 255, 1, 0, 195075),
			row(KEEP_COUNT, MODE_QUERY, 0,   0,   255, 0,   1, 0, 65025),
			row(KEEP_COUNT, MODE_LOAD,  255, 255, 255, 255, 0, 0, 0),
			row(KEEP_COUNT, MODE_LOAD,  0,   255, 255, 255, 0, 0, 0),
			row(KEEP_COUNT, MODE_QUERY, 0,   0,   0,   0,   1, 0, 195075),
			row(KEEP_COUNT, MODE_QUERY, 0,   255, 255, 255, 1, 0, 0),
			row(KEEP_COUNT, MODE_LOAD,  1,   255, 255, 255, 0, 0, 0),
			row(2,          MODE_QUERY, 0,   255, 255, 255, 1, 0, 0),
			row(KEEP_COUNT, MODE_QUERY, 0,   1,   2,   3,   0, 0, 0),
			row(KEEP_COUNT, MODE_LOAD,  1,   0,   0,   0,   0, 0, 0),
			row(KEEP_COUNT, MODE_QUERY, 0,   0,   0,   0,   1, 1, 0),
			row(KEEP_COUNT, MODE_QUERY, 0,   128, 128, 128, 0, 0, 0),
			row(KEEP_COUNT, MODE_QUERY, 0,   127, 127, 127, 0, 0, 0),
			row(KEEP_COUNT, MODE_LOAD,  2,   128, 128, 128, 0, 0, 0),
			row(3,          MODE_QUERY, 0,   128, 128, 128, 1, 2, 0),
			row(KEEP_COUNT, MODE_QUERY, 0,   85,  170, 85,  0, 0, 0),
			row(KEEP_COUNT, MODE_QUERY, 0,   170, 85,  170, 0, 0, 0),
			row(1,          MODE_QUERY, 0,   0,   0,   0,   1, 0, 195075)
		};

		// Random phases: entry count, sender idle percent, receiver stall percent.
		// The count of 511 saturates the scan, zero falls back to one entry.
		phases = '{
			'{511,         0,  0},
			'{256,         63, 0},
			'{1,           0,  63},
			'{PICK_RANDOM, 35, 35},
			'{255,         0,  0},
			'{0,           63, 0},
			'{2,           0,  63},
			'{PICK_RANDOM, 35, 35},
			'{128,         0,  0}
		};

		// Hold reset, then release it on a falling edge.
		repeat (12) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (directed_rows[r]) begin
			if (directed_rows[r].count_cfg != KEEP_COUNT)
				set_entry_count(directed_rows[r].count_cfg);
			offer_beat(directed_rows[r].beat, directed_rows[r].has_exp, directed_rows[r].exp_res);
		end

		// Write every entry once so no later scan can touch an unwritten one.
		for (int i = 0; i < MAX_CELLS; i++) begin
			beat             = pick_beat();
			beat.mode        = MODE_LOAD;
			beat.entry_index = IDX_W'(i);
			offer_beat(beat, 1'b0, '0);
		end

		foreach (phases[p]) begin
			cfg = phases[p].count_cfg;
			if (cfg == PICK_RANDOM)
				cfg = $urandom_range(254, 3);
			set_entry_count(cfg);
			send_idle_pct  = phases[p].send_idle_pct;
			recv_stall_pct = phases[p].recv_stall_pct;
			for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
				// Halfway through one phase, stop offering until every answer is back.
				if (p == PAUSE_PHASE && n == ITEMS_PER_PHASE / 2) begin
					item_valid <= 1'b0;
					do begin
						@(negedge clk);
					end while (pending_nearest.size() != 0);
				end
				// Early in another, hold the result side off long enough to back up the input.
				if (p == HOLD_PHASE && n == 10)
					holdoff_req = 1'b1;
				offer_beat(pick_beat(), 1'b0, '0);
			end
		end

		// Drain: wait for every owed answer, then one more scan for stray output.
		item_valid <= 1'b0;
		do begin
			@(negedge clk);
		end while (pending_nearest.size() != 0);
		repeat (DRAIN_CYCLES) @(negedge clk);

		if (miss_count == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
